// ===== hdl/tuc_pkg.sv =====
// tuc_pkg: shared types and constants of the tcp/udp checksum engine
// depends on nothing; used by every module
package tuc_pkg;

    // item codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // protocol numbers carried in the pseudo-header
    localparam logic [15:0] PROTO_TCP = 16'd6;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    // position of the checksum field inside the segment, in 16-bit words
    localparam logic [14:0] CSUM_WORD_TCP = 15'd8;
    localparam logic [14:0] CSUM_WORD_UDP = 15'd3;
    localparam logic [14:0] INDEX_MAX     = 15'h7FFF;

    localparam logic [15:0] ALL_ONES = 16'hFFFF;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // classified item as it travels through the queue
    typedef struct packed {
        logic        is_start;
        logic [15:0] psum;
        logic        tcp;
        logic        odd;
        logic [15:0] data_word;
        logic        last;
    } t_item;

endpackage

// ===== hdl/tuc_if.sv =====
// tuc_if: valid/ready channel interfaces of the checksum engine
// depends on nothing; widths follow the item fields
interface tuc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        is_tcp;
    logic [15:0] ip_total_length;
    logic [3:0]  ip_header_words;
    logic [15:0] data_word;
    logic        last;

    modport source (
        output valid, op, src_addr, dst_addr, is_tcp, ip_total_length,
               ip_header_words, data_word, last,
        input  ready
    );
    modport sink (
        input  valid, op, src_addr, dst_addr, is_tcp, ip_total_length,
               ip_header_words, data_word, last,
        output ready
    );
endinterface

interface tuc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink (input valid, checksum, output ready);
endinterface

// ===== hdl/tuc_front.sv =====
// tuc_front: accepts requests, classifies them and folds the pseudo-header sum
// depends on tuc_pkg and tuc_in_if
module tuc_front (
    tuc_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_wr_valid,
    output tuc_pkg::t_item  o_wr_item
);

    logic [15:0] seglen;
    logic [15:0] proto;
    logic [18:0] wide_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // segment length from total length and header length, wraps mod 2^16
    assign seglen = i_in.ip_total_length - {10'd0, i_in.ip_header_words, 2'b00};
    assign proto  = i_in.is_tcp ? tuc_pkg::PROTO_TCP : tuc_pkg::PROTO_UDP;

    // pseudo-header: six halves summed wide, then folded twice
    assign wide_sum = {3'd0, i_in.src_addr[31:16]} + {3'd0, i_in.src_addr[15:0]}
                    + {3'd0, i_in.dst_addr[31:16]}
                    + {3'd0, i_in.dst_addr[15:0]}
                    + {3'd0, proto} + {3'd0, seglen};
    assign fold1 = {1'b0, wide_sum[15:0]} + {14'd0, wide_sum[18:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

    // handshake: take a request whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_wr_valid = i_in.valid && !i_full;

    // classified item
    always_comb begin
        o_wr_item.is_start  = (i_in.op == tuc_pkg::OP_START);
        o_wr_item.psum      = fold2;
        o_wr_item.tcp       = i_in.is_tcp;
        o_wr_item.odd       = seglen[0];
        o_wr_item.data_word = i_in.data_word;
        o_wr_item.last      = i_in.last;
    end

endmodule

// ===== hdl/tuc_queue.sv =====
// tuc_queue: short register queue between front and back
// depends on tuc_pkg
module tuc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    input  tuc_pkg::t_item  i_wr_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_rd_valid,
    output tuc_pkg::t_item  o_rd_item
);

    tuc_pkg::t_item r_mem [tuc_pkg::QUEUE_DEPTH];
    logic [tuc_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [tuc_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [tuc_pkg::QUEUE_AW:0]   r_count,  n_count;
    logic push, pop;

    assign o_full     = (r_count == (tuc_pkg::QUEUE_AW+1)'(tuc_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && !o_full;
    assign pop        = i_pop && o_rd_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

// ===== hdl/tuc_back.sv =====
// tuc_back: running ones-complement sum, final fold and result register
// depends on tuc_pkg and tuc_out_if
module tuc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_valid,
    input  tuc_pkg::t_item  i_rd_item,
    output logic            o_pop,
    tuc_out_if.source       o_out
);

    logic [15:0] r_sum,   n_sum;
    logic [14:0] r_index, n_index;
    logic        r_tcp,   n_tcp;
    logic        r_odd,   n_odd;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_checksum,  n_checksum;

    logic        need_out;
    logic [14:0] csum_at;
    logic [15:0] word;
    logic [16:0] add_wide;
    logic [15:0] add_sum;
    logic [15:0] inverted;

    // only a last word needs the result register free or draining
    assign need_out = !i_rd_item.is_start && i_rd_item.last;
    assign o_pop    = i_rd_valid && (!need_out || !r_out_valid || o_out.ready);

    // data word with checksum field and pad byte masked
    always_comb begin
        csum_at = r_tcp ? tuc_pkg::CSUM_WORD_TCP : tuc_pkg::CSUM_WORD_UDP;
        word    = i_rd_item.data_word;
        if (r_index == csum_at) begin
            word = '0;
        end
        if (i_rd_item.last && r_odd) begin
            word[7:0] = 8'h00;
        end
        add_wide = {1'b0, r_sum} + {1'b0, word};
        add_sum  = add_wide[15:0] + {15'd0, add_wide[16]};
        inverted = ~add_sum;
    end

    // state update and result capture
    always_comb begin
        n_sum       = r_sum;
        n_index     = r_index;
        n_tcp       = r_tcp;
        n_odd       = r_odd;
        n_out_valid = r_out_valid && !o_out.ready;
        n_checksum  = r_checksum;
        if (o_pop) begin
            if (i_rd_item.is_start) begin
                n_sum   = i_rd_item.psum;
                n_index = '0;
                n_tcp   = i_rd_item.tcp;
                n_odd   = i_rd_item.odd;
            end else if (i_rd_item.last) begin
                n_sum       = '0;
                n_index     = '0;
                n_out_valid = 1'b1;
                // udp reserves zero for no checksum
                n_checksum  = (!r_tcp && inverted == '0) ? tuc_pkg::ALL_ONES : inverted;
            end else begin
                n_sum   = add_sum;
                n_index = (r_index < tuc_pkg::INDEX_MAX) ? r_index + 1'b1 : r_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_index     <= '0;
            r_tcp       <= 1'b0;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_index     <= n_index;
            r_tcp       <= n_tcp;
            r_odd       <= n_odd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_checksum <= n_checksum;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.checksum = r_checksum;

endmodule

// ===== hdl/tcp_udp_checksum_engine_unit.sv =====
// tcp_udp_checksum_engine_unit: top level of the tcp/udp checksum engine
// depends on tuc_pkg, tuc_if, tuc_front, tuc_queue and tuc_back
//
// Computes the TCP or UDP checksum of a segment. A start request loads the
// pseudo-header (addresses, protocol, segment length from total length less
// the IP header); each data request adds one 16-bit word, the checksum field
// counting as zero and an odd tail byte padded; the request marked last gives
// the inverted folded sum, a UDP zero being sent as all ones. One request is
// taken every clock while the queue has room: the front folds the
// pseudo-header combinationally and writes a four-entry queue, the back does
// one end-around-carry add per cycle, and the result waits in an output
// register; a last word stalls the back while that register is still held.
module tcp_udp_checksum_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tuc_in_if.sink     i_in,
    tuc_out_if.source  o_out
);

    logic           wr_valid;
    tuc_pkg::t_item wr_item;
    logic           full;
    logic           pop;
    logic           rd_valid;
    tuc_pkg::t_item rd_item;

    // classification and pseudo-header
    tuc_front u_front (
        .i_in       (i_in),
        .i_full     (full),
        .o_wr_valid (wr_valid),
        .o_wr_item  (wr_item)
    );

    // decoupling queue
    tuc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .i_wr_item  (wr_item),
        .o_full     (full),
        .i_pop      (pop),
        .o_rd_valid (rd_valid),
        .o_rd_item  (rd_item)
    );

    // running sum and result
    tuc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (rd_valid),
        .i_rd_item  (rd_item),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ===== tb/sv/checksum_watch.sv =====
// checksum_watch: follows both channels of the checksum engine, predicts each checksum
// and compares it with what the engine hands out
// depends on tuc_pkg and the channel interfaces in tuc_if
module checksum_watch
    import tuc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tuc_in_if    i_in,
    tuc_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted engine state
    logic [15:0] run_sum;
    logic [14:0] word_pos;
    logic        tcp_sel;
    logic        odd_seg;

    // checksums still owed by the engine, oldest first
    logic [15:0] expected_sums[$];
    logic [15:0] oldest;
    int          fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // ones-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // fold one accepted request into the predicted state
    task automatic take_request();
        logic [15:0] seg_len;
        logic [15:0] acc;
        logic [15:0] w;
        logic [15:0] csum;
        logic [14:0] csum_pos;
        if (i_in.op == OP_START) begin
            // pseudo-header: addresses, protocol, segment length (wraps when short)
            seg_len = i_in.ip_total_length - {10'd0, i_in.ip_header_words, 2'b00};
            acc = ones_add(16'h0000, i_in.src_addr[31:16]);
            acc = ones_add(acc, i_in.src_addr[15:0]);
            acc = ones_add(acc, i_in.dst_addr[31:16]);
            acc = ones_add(acc, i_in.dst_addr[15:0]);
            acc = ones_add(acc, i_in.is_tcp ? PROTO_TCP : PROTO_UDP);
            acc = ones_add(acc, seg_len);
            run_sum  = acc;
            word_pos = '0;
            tcp_sel  = i_in.is_tcp;
            odd_seg  = seg_len[0];
        end else begin
            // checksum field counts as zero, odd tail byte padded
            csum_pos = tcp_sel ? CSUM_WORD_TCP : CSUM_WORD_UDP;
            w = (word_pos == csum_pos) ? 16'h0000 : i_in.data_word;
            if (i_in.last && odd_seg) w[7:0] = 8'h00;
            run_sum = ones_add(run_sum, w);
            if (word_pos != INDEX_MAX) word_pos = word_pos + 15'd1;
            if (i_in.last) begin
                csum = ~run_sum;
                // udp sends a zero checksum as all ones
                if (!tcp_sel && csum == 16'h0000) csum = ALL_ONES;
                expected_sums.push_back(csum);
                run_sum  = '0;
                word_pos = '0;
            end
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_sum  = '0;
            word_pos = '0;
            tcp_sel  = 1'b0;
            odd_seg  = 1'b0;
            expected_sums.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_sums.size() == 0) begin
                    $error("checksum: got %h with nothing expected", i_out.checksum);
                    fail_count++;
                end else begin
                    oldest = expected_sums.pop_front();
                    if (i_out.checksum !== oldest) begin
                        $error("checksum: expected %h, actual %h", oldest, i_out.checksum);
                        fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) take_request();
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_sums.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives start and segment-word requests into the checksum engine with random
// gaps and output stalls, then gives the verdict from checksum_watch
// depends on tuc_pkg, tuc_if, tcp_udp_checksum_engine_unit and checksum_watch
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tuc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic no_idle = 1'b0;
    int   sent = 0;
    int   fail_count;
    int   pending;
    int   kind;
    int   n_words;

    tuc_in_if  in_ch ();
    tuc_out_if out_ch ();

    tcp_udp_checksum_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    checksum_watch watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #3000000;
        $display("testbench: FAIL");
        $finish;
    end

    // result side stalls
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    // segment word with the extremes weighted in
    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'hFFFF;
        if (r < 15) return 16'h0000;
        return 16'($urandom);
    endfunction

    // ip header length, now and then below the legal minimum
    function automatic logic [3:0] rand_ihl();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 4));
        return 4'($urandom_range(5, 15));
    endfunction

    // present one request and wait until it is taken
    task automatic send_request(input logic op, input logic [31:0] sip, input logic [31:0] dip,
                                input logic tcp, input logic [15:0] total,
                                input logic [3:0] ihl, input logic [15:0] word,
                                input logic last);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.op              <= op;
        in_ch.src_addr        <= sip;
        in_ch.dst_addr        <= dip;
        in_ch.is_tcp          <= tcp;
        in_ch.ip_total_length <= total;
        in_ch.ip_header_words <= ihl;
        in_ch.data_word       <= word;
        in_ch.last            <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // start request, unused fields random
    task automatic send_start(input logic [31:0] sip, input logic [31:0] dip, input logic tcp,
                              input logic [15:0] total, input logic [3:0] ihl,
                              input logic last);
        send_request(OP_START, sip, dip, tcp, total, ihl, 16'($urandom), last);
    endtask

    // segment word request, unused fields random
    task automatic send_data(input logic [15:0] word, input logic last);
        send_request(OP_DATA, $urandom, $urandom, 1'($urandom), 16'($urandom),
                     4'($urandom), word, last);
    endtask

    // start with random addresses, then n words; length consistent about half the time
    task automatic send_packet(input int n, input logic with_last);
        logic [3:0]  ihl;
        logic [15:0] total;
        ihl = rand_ihl();
        if ($urandom_range(0, 1) == 0) total = 16'($urandom);
        else total = 16'({ihl, 2'b00} + 2 * n - $urandom_range(0, 1));
        send_start($urandom, $urandom, 1'($urandom), total, ihl, 1'($urandom_range(0, 9) == 0));
        for (int i = 0; i < n; i++) send_data(rand_word(), with_last && (i == n - 1));
    endtask

    // stimulus and verdict
    initial begin
        in_ch.valid           <= 1'b0;
        in_ch.op              <= OP_START;
        in_ch.src_addr        <= '0;
        in_ch.dst_addr        <= '0;
        in_ch.is_tcp          <= 1'b0;
        in_ch.ip_total_length <= '0;
        in_ch.ip_header_words <= '0;
        in_ch.data_word       <= '0;
        in_ch.last            <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data straight after reset, sum becomes all ones so udp zero is remapped
        send_data(16'hFFFF, 1'b1);

        // udp, extreme addresses and length, checksum field nonzero, odd tail
        send_start(32'hFFFFFFFF, 32'h00000000, 1'b0, 16'hFFFF, 4'd15, 1'b0);
        send_data(16'h1234, 1'b0);
        send_data(16'h5678, 1'b0);
        send_data(16'h9ABC, 1'b0);
        send_data(16'hDEAD, 1'b0);
        send_data(16'hFFFF, 1'b1);

        // tcp, short total length wraps, last on the start is ignored,
        // last word sits on the checksum field
        send_start(32'h00000000, 32'hFFFFFFFF, 1'b1, 16'h0000, 4'd5, 1'b1);
        for (int i = 0; i < 9; i++) send_data(16'hA5A5 ^ 16'(i), i == 8);

        // tcp zero checksum stays zero
        send_start(32'h0, 32'h0, 1'b1, 16'd20, 4'd5, 1'b0);
        send_data(16'hFFF9, 1'b1);

        // udp zero checksum goes out as all ones
        send_start(32'h0, 32'h0, 1'b0, 16'd20, 4'd5, 1'b0);
        send_data(16'hFFEE, 1'b1);

        // header length below five, then a restart in mid-packet
        send_start(32'h0A000001, 32'hC0A80001, 1'b1, 16'd40, 4'd0, 1'b0);
        send_data(16'h0F0F, 1'b0);
        send_start(32'h0A000002, 32'hC0A80002, 1'b0, 16'd31, 4'd3, 1'b0);
        send_data(16'hF0F0, 1'b1);

        // words with no start after a finished packet, mode carried over
        send_data(16'h0001, 1'b0);
        send_data(16'h0000, 1'b1);

        // random packets, mostly well formed
        while (sent < 1040) begin
            no_idle <= (sent >= 450 && sent < 650);
            kind    = $urandom_range(0, 99);
            n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 60)
                                                   : $urandom_range(1, 24);
            if (kind < 80) begin
                send_packet(n_words, 1'b1);
            end else if (kind < 88) begin
                // broken packet, next start cuts it off
                send_packet($urandom_range(0, 10), 1'b0);
            end else if (kind < 94) begin
                // loose words with no start
                for (int i = 0; i < n_words % 6 + 1; i++)
                    send_data(rand_word(), 1'($urandom_range(0, 3) == 0));
            end else begin
                send_start($urandom, $urandom, 1'($urandom), 16'($urandom), rand_ihl(),
                           1'b1);
            end
        end
        in_ch.valid <= 1'b0;

        // drain the results, then allow for the pipeline
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tuc_pkg.sv
hdl/tuc_if.sv
hdl/tuc_front.sv
hdl/tuc_queue.sv
hdl/tuc_back.sv
hdl/tcp_udp_checksum_engine_unit.sv
tb/sv/checksum_watch.sv
tb/sv/testbench.sv
